// ===== rtl/core/cbs_pkg.sv =====
// Shared types and constants of the cubic Bezier segment sampler.
// No dependencies; used by rtl/core/cubic_bezier_segment_sampler.sv.
package cbs_pkg;

	// Number of control points in a segment, and of coordinate axes.
	localparam int NUM_PTS  = 4;
	localparam int NUM_AXES = 2;

	// Axis positions inside the per-axis arrays.
	localparam int AXIS_X = 0;
	localparam int AXIS_Y = 1;

	// Binomial factors of the cubic Bernstein basis, in control point order.
	localparam logic [1:0] BINOM [NUM_PTS] = '{2'd1, 2'd3, 2'd3, 2'd1};
	localparam logic [1:0] BINOM_THREE = 2'd3;

	// Control bits that travel down the pipeline with each sample.
	typedef struct packed {
		logic valid;
		logic last;
	} ctl_t;

endpackage

// ===== rtl/core/cubic_bezier_segment_sampler.sv =====
// Cubic Bezier segment sampler: sample sequencer and six-stage evaluation pipeline.
// Depends on cbs_pkg (rtl/core/cbs_pkg.sv).
//
// Usage:
// A request on the input channel (in_valid/in_ready) carries one segment as four
// control points p0..p3, each x and y in signed Q12.4. The block then sends one
// request per sample on the output channel (out_valid/out_ready) for
// t = 0, t_step, 2*t_step ... while t <= 1, at most MAX_SAMPLES of them, with
// last_sample high on the final one. t_step is to be written by the user through
// t_step_we/t_step only while the block is idle; the block itself does not enforce
// this. It resets to 1/20 of the unit parameter.
// Throughput: one sample per cycle while the receiver takes them. A new segment is
// accepted only once the last sample of the previous one has read the held control
// points into stage 4.
// Reset clears the sequencer, all pipeline valid bits and the output request; the
// step register returns to its reset value.
// When the receiver stalls, the whole pipeline and the sample sequencer hold, so
// no sample is dropped or repeated.
module cubic_bezier_segment_sampler #(
	parameter int COORD_WIDTH = 16,
	parameter int T_FRAC_BITS = 16,
	parameter int MAX_SAMPLES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          t_step_we,
	input  logic [T_FRAC_BITS:0]          t_step,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] p0_x,
	input  logic signed [COORD_WIDTH-1:0] p0_y,
	input  logic signed [COORD_WIDTH-1:0] p1_x,
	input  logic signed [COORD_WIDTH-1:0] p1_y,
	input  logic signed [COORD_WIDTH-1:0] p2_x,
	input  logic signed [COORD_WIDTH-1:0] p2_y,
	input  logic signed [COORD_WIDTH-1:0] p3_x,
	input  logic signed [COORD_WIDTH-1:0] p3_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] curve_x,
	output logic signed [COORD_WIDTH-1:0] curve_y,
	output logic                          last_sample
);

	localparam int T_W    = T_FRAC_BITS + 1;
	localparam int SQ_W   = 2 * T_FRAC_BITS + 1;
	localparam int CU_W   = 3 * T_FRAC_BITS + 1;
	localparam int SH     = 3 * T_FRAC_BITS;
	localparam int PT_W   = COORD_WIDTH + 2;
	localparam int ACC_W  = CU_W + 1 + PT_W;
	localparam int RND_W  = COORD_WIDTH + 4;
	localparam int CNT_W  = $clog2(MAX_SAMPLES);
	localparam int NP     = cbs_pkg::NUM_PTS;
	localparam int NA     = cbs_pkg::NUM_AXES;

	localparam logic [T_W-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
	// Reset step is 1/20 of the unit, rounded to nearest.
	localparam logic [T_W-1:0] STEP_RST =
		T_W'(((2 ** (T_FRAC_BITS + 1)) / 20 + 1) / 2);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_SAMPLES - 1);
	localparam logic signed [ACC_W-1:0] HALF = {{(ACC_W - SH){1'b0}}, 1'b1, {(SH - 1){1'b0}}};
	localparam logic signed [RND_W-1:0] LIM_HI = {5'b00000, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic signed [RND_W-1:0] LIM_LO = {5'b11111, {(COORD_WIDTH - 1){1'b0}}};

	// Step register.
	logic [T_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RST;
		end else if (t_step_we) begin
			step_q <= t_step;
		end
	end

	// Pipeline advance: everything moves unless the output request is stalled.
	cbs_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic adv;
	logic accept;

	assign adv    = !ctl_s6.valid || out_ready;
	assign accept = in_valid && in_ready;

	// Held control points, captured when a segment is accepted.
	logic signed [COORD_WIDTH-1:0] hold_q [2 * NP];

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_q[0] <= p0_x;
			hold_q[1] <= p0_y;
			hold_q[2] <= p1_x;
			hold_q[3] <= p1_y;
			hold_q[4] <= p2_x;
			hold_q[5] <= p2_y;
			hold_q[6] <= p3_x;
			hold_q[7] <= p3_y;
		end
	end

	// Sample sequencer: walks t and counts samples of the current segment.
	logic             busy_q;
	logic [T_W-1:0]   t_q;
	logic [CNT_W-1:0] n_q;
	logic [T_W:0]     next_t;
	logic             is_last;
	logic             issue;

	assign next_t  = {1'b0, t_q} + {1'b0, step_q};
	assign is_last = (next_t > {1'b0, T_ONE}) || (n_q == CNT_LAST);
	assign issue   = busy_q && adv;
	assign in_ready = !busy_q && !ctl_s1.valid && !ctl_s2.valid && !ctl_s3.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			t_q    <= '0;
			n_q    <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			t_q    <= '0;
			n_q    <= '0;
		end else if (issue) begin
			if (is_last) begin
				busy_q <= 1'b0;
				t_q    <= '0;
				n_q    <= '0;
			end else begin
				t_q <= next_t[T_W-1:0];
				n_q <= n_q + 1'b1;
			end
		end
	end

	// Control bits of all stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= issue;
			ctl_s1.last  <= is_last;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
		end
	end

	// Stage 1: t and its complement u = 1 - t.
	logic [T_W-1:0] t_s1, u_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= t_q;
			u_s1 <= T_ONE - t_q;
		end
	end

	// Stage 2: second-order products u^2, u*t, t^2.
	logic [2*T_W-1:0] uu_p, ut_p, tt_p;
	logic [SQ_W-1:0]  u2_s2, ut_s2, t2_s2;
	logic [T_W-1:0]   t_s2, u_s2;

	assign uu_p = u_s1 * u_s1;
	assign ut_p = u_s1 * t_s1;
	assign tt_p = t_s1 * t_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			u2_s2 <= uu_p[SQ_W-1:0];
			ut_s2 <= ut_p[SQ_W-1:0];
			t2_s2 <= tt_p[SQ_W-1:0];
			t_s2  <= t_s1;
			u_s2  <= u_s1;
		end
	end

	// Stage 3: cubic basis terms without binomial factors.
	logic [SQ_W+T_W-1:0] cu_p [NP];
	logic [CU_W-1:0]     w_s3 [NP];

	assign cu_p[0] = u2_s2 * u_s2;
	assign cu_p[1] = u2_s2 * t_s2;
	assign cu_p[2] = ut_s2 * t_s2;
	assign cu_p[3] = t2_s2 * t_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NP; i++) begin
				w_s3[i] <= cu_p[i][CU_W-1:0];
			end
		end
	end

	// Stage 4: weight times control point, binomial factor folded into the point.
	logic signed [COORD_WIDTH-1:0] pt   [NA][NP];
	logic signed [PT_W-1:0]        pt_k [NA][NP];
	logic signed [ACC_W-1:0]       m_s4 [NA][NP];

	always_comb begin
		for (int i = 0; i < NP; i++) begin
			pt[cbs_pkg::AXIS_X][i] = hold_q[2 * i];
			pt[cbs_pkg::AXIS_Y][i] = hold_q[2 * i + 1];
		end
		for (int a = 0; a < NA; a++) begin
			for (int i = 0; i < NP; i++) begin
				if (cbs_pkg::BINOM[i] == cbs_pkg::BINOM_THREE) begin
					pt_k[a][i] = PT_W'(pt[a][i]) + (PT_W'(pt[a][i]) <<< 1);
				end else begin
					pt_k[a][i] = PT_W'(pt[a][i]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < NA; a++) begin
				for (int i = 0; i < NP; i++) begin
					m_s4[a][i] <= $signed({1'b0, w_s3[i]}) * pt_k[a][i];
				end
			end
		end
	end

	// Stage 5: exact sum, round half up, drop the fraction bits.
	logic signed [ACC_W-1:0] acc   [NA];
	logic signed [ACC_W-1:0] acc_sh[NA];
	logic signed [RND_W-1:0] r_s5  [NA];

	always_comb begin
		for (int a = 0; a < NA; a++) begin
			acc[a]    = m_s4[a][0] + m_s4[a][1] + m_s4[a][2] + m_s4[a][3] + HALF;
			acc_sh[a] = acc[a] >>> SH;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < NA; a++) begin
				r_s5[a] <= $signed(acc_sh[a][RND_W-1:0]);
			end
		end
	end

	// Stage 6: saturate into the output register.
	logic signed [COORD_WIDTH-1:0] c_s6 [NA];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < NA; a++) begin
				if (r_s5[a] > LIM_HI) begin
					c_s6[a] <= LIM_HI[COORD_WIDTH-1:0];
				end else if (r_s5[a] < LIM_LO) begin
					c_s6[a] <= LIM_LO[COORD_WIDTH-1:0];
				end else begin
					c_s6[a] <= r_s5[a][COORD_WIDTH-1:0];
				end
			end
		end
	end

	assign out_valid   = ctl_s6.valid;
	assign curve_x     = c_s6[cbs_pkg::AXIS_X];
	assign curve_y     = c_s6[cbs_pkg::AXIS_Y];
	assign last_sample = ctl_s6.last;

	// A segment is never accepted while the sequencer is still walking one.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !accept)
		else $error("segment accepted while sampling");

	// The parameter handed to the pipeline never passes one.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (t_q <= T_ONE))
		else $error("sample parameter above one");

	// Reaching the sample cap ends the segment.
	assert property (@(posedge clk) disable iff (!arst_n)
		(issue && n_q == CNT_LAST) |=> !busy_q)
		else $error("sample cap exceeded");

	// An accepted segment starts at t = 0 with an empty count.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && t_q == '0 && n_q == '0))
		else $error("segment did not start at zero");

	// The first held coordinate stays put while a sample in stage 3 still reads the held points.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s3.valid && !accept) |=> $stable(hold_q[0]))
		else $error("held points changed under a sample");

endmodule
